>>> sv/fnac_pkg.sv
// Shared types and constants for the framewise normalised autocorrelation block.
// No dependencies. Imported by the interfaces, fnac_scale and the top level.
`default_nettype none

package fnac_pkg;

  // Parameter defaults
  localparam int unsigned MAX_WINDOW_DEF  = 1024;
  localparam int unsigned MAX_LAGS_DEF    = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned STORE_DEPTH_DEF = 2048;

  // Register widths
  localparam int unsigned WIN_REG_W   = 11;
  localparam int unsigned LAGS_REG_W  = 7;
  localparam int unsigned HOP_REG_W   = 11;
  localparam int unsigned LIMIT_REG_W = 16;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned CFG_IDX_W   = 2;

  // Register reset values
  localparam logic [WIN_REG_W-1:0]   WIN_RST   = 11'd256;
  localparam logic [LAGS_REG_W-1:0]  LAGS_RST  = 7'd64;
  localparam logic [HOP_REG_W-1:0]   HOP_RST   = 11'd128;
  localparam logic [LIMIT_REG_W-1:0] LIMIT_RST = 16'hFFFF;

  // Result field widths
  localparam int unsigned LAG_IDX_W = 6;
  localparam int unsigned CORR_W    = 42;
  localparam int unsigned SCALE_W   = 41;
  localparam int unsigned FRAME_W   = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW = 2'd0,
    CFG_LAGS   = 2'd1,
    CFG_HOP    = 2'd2,
    CFG_LIMIT  = 2'd3
  } fnac_cfg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_HAND
  } fnac_state_e;

  typedef enum logic [1:0] {
    SC_IDLE,
    SC_MUL,
    SC_ROOT,
    SC_DONE
  } fnac_sc_state_e;

  typedef struct packed {
    logic start;
    logic take;
  } fnac_sc_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fnac_sc_sts_t;

endpackage

`default_nettype wire

>>> sv/fnac_sample_if.sv
// Input channel: one sample beat with its restart flag.
// Depends on fnac_pkg.
`default_nettype none

interface fnac_sample_if
  import fnac_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;
  logic                   restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface

`default_nettype wire

>>> sv/fnac_result_if.sv
// Output channel: one correlation result beat per lag.
// Depends on fnac_pkg.
`default_nettype none

interface fnac_result_if
  import fnac_pkg::*;
;
  logic                      valid;
  logic                      ready;
  logic [LAG_IDX_W-1:0]      lag_index;
  logic signed [CORR_W-1:0]  correlation;
  logic [SCALE_W-1:0]        scale;
  logic [FRAME_W-1:0]        frame_index;
  logic                      last_lag;

  modport source (output valid, output lag_index, output correlation, output scale,
                  output frame_index, output last_lag, input ready);
  modport sink   (input valid, input lag_index, input correlation, input scale,
                  input frame_index, input last_lag, output ready);
endinterface

`default_nettype wire

>>> sv/fnac_scale.sv
// Scale unit: shift-add product of two operands, then bit-pair floor square root.
// Depends on fnac_pkg. Used by the top level.
`default_nettype none

module fnac_scale
  import fnac_pkg::*;
#(
  parameter int unsigned OP_W = 43
)(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fnac_sc_req_t    req_i,
  input  logic [OP_W-1:0] r0_i,
  input  logic [OP_W-1:0] energy_i,
  output fnac_sc_sts_t    sts_o,
  output logic [OP_W-1:0] root_o
);
  localparam int unsigned PW    = 2 * OP_W;
  localparam int unsigned CNT_W = $clog2(OP_W + 1);

  fnac_sc_state_e    state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [PW-1:0]     mcand_q, mcand_d;
  logic [OP_W-1:0]   mplier_q, mplier_d;
  logic [PW-1:0]     acc_q, acc_d;
  logic [OP_W+1:0]   rem_q, rem_d;
  logic [OP_W-1:0]   root_q, root_d;
  logic [OP_W+1:0]   rem_sh, trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SC_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
    acc_q    <= acc_d;
    rem_q    <= rem_d;
    root_q   <= root_d;
  end

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    acc_d    = acc_q;
    rem_d    = rem_q;
    root_d   = root_q;
    rem_sh   = {rem_q[OP_W-1:0], acc_q[PW-1 -: 2]};
    trial    = {root_q, 2'b01};
    unique case (state_q)
      SC_IDLE: begin
        if (req_i.start) begin
          mcand_d  = PW'(r0_i);
          mplier_d = energy_i;
          acc_d    = '0;
          cnt_d    = '0;
          state_d  = SC_MUL;
        end
      end
      SC_MUL: begin
        if (mplier_q[0]) acc_d = acc_q + mcand_q;
        mcand_d  = mcand_q << 1;
        mplier_d = mplier_q >> 1;
        cnt_d    = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OP_W - 1)) begin
          cnt_d   = '0;
          rem_d   = '0;
          root_d  = '0;
          state_d = SC_ROOT;
        end
      end
      SC_ROOT: begin
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[OP_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[OP_W-2:0], 1'b0};
        end
        acc_d = acc_q << 2;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(OP_W - 1)) state_d = SC_DONE;
      end
      SC_DONE: begin
        if (req_i.take) state_d = SC_IDLE;
      end
      default: state_d = SC_IDLE;
    endcase
  end

  assign sts_o.busy = (state_q != SC_IDLE);
  assign sts_o.done = (state_q == SC_DONE);
  assign root_o     = root_q;

endmodule

`default_nettype wire

>>> sv/framewise_normalized_autocorrelation_top.sv
// Framewise normalised autocorrelation: sample store, MAC sequencer, output register.
// Depends on fnac_pkg, fnac_sample_if, fnac_result_if and fnac_scale.
//
//  channel   dir  handshake            payload
//  in_if     in   valid/ready          sample, restart
//  out_if    out  valid/ready          lag_index, correlation, scale, frame_index, last_lag
//  cfg       in   cfg_we_i (no ready)  cfg_idx_i, cfg_data_i
//
// A sample beat that completes no frame leaves in_if.ready high. A beat that completes a
// frame holds in_if.ready low while the single multiply-accumulate unit walks the
// window once per lag, one sample pair per cycle, read from the two-read-port store.
// The square root for each lag runs in fnac_scale alongside the next lag; a lag is
// handed over only once the scale unit has run its multiply, root and done states
// and is idle again, and ready returns once the last lag of the frame has been
// handed to the scale unit.
// Reset clears control state only; no unwritten store entry ever reaches a result.
// A stalled output holds the scale unit, which in turn holds the MAC sequencer.
`default_nettype none

module framewise_normalized_autocorrelation_top
  import fnac_pkg::*;
#(
  parameter int unsigned MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int unsigned MAX_LAGS    = MAX_LAGS_DEF,
  parameter int unsigned SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int unsigned STORE_DEPTH = STORE_DEPTH_DEF
)(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  fnac_sample_if.sink           in_if,
  fnac_result_if.source         out_if
);
  localparam int unsigned AW    = $clog2(STORE_DEPTH);
  localparam int unsigned NW_S  = $clog2(STORE_DEPTH + 1);
  localparam int unsigned NW_W  = $clog2(MAX_WINDOW + 1);
  localparam int unsigned NW_SW = (NW_S > NW_W) ? NW_S : NW_W;
  // counts, clamped register values and fill level share one width
  localparam int unsigned NW    = ((NW_SW > 12) ? NW_SW : 12) + 1;
  localparam int unsigned ETA_W = (MAX_LAGS > 1) ? $clog2(MAX_LAGS) : 1;
  localparam int unsigned PRD_W = 2 * SAMPLE_BITS;
  localparam int unsigned ACC_W = PRD_W + $clog2(MAX_WINDOW) + 1;

  // ---------------- configuration registers ----------------
  logic [WIN_REG_W-1:0]   win_q;
  logic [LAGS_REG_W-1:0]  lags_q;
  logic [HOP_REG_W-1:0]   hop_q;
  logic [LIMIT_REG_W-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q   <= WIN_RST;
      lags_q  <= LAGS_RST;
      hop_q   <= HOP_RST;
      limit_q <= LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (fnac_cfg_e'(cfg_idx_i))
        CFG_WINDOW: win_q   <= cfg_data_i[WIN_REG_W-1:0];
        CFG_LAGS:   lags_q  <= cfg_data_i[LAGS_REG_W-1:0];
        CFG_HOP:    hop_q   <= cfg_data_i[HOP_REG_W-1:0];
        CFG_LIMIT:  limit_q <= cfg_data_i[LIMIT_REG_W-1:0];
        default:    ;
      endcase
    end
  end

  // clamped: zero acts as one, lags <= MAX_LAGS, window <= MAX_WINDOW and store depth
  logic [NW-1:0] lags_c, win_c, hop_c, need_c;
  always_comb begin
    lags_c = (lags_q == '0) ? NW'(1) : NW'(lags_q);
    if (lags_c > NW'(MAX_LAGS)) lags_c = NW'(MAX_LAGS);
    win_c = (win_q == '0) ? NW'(1) : NW'(win_q);
    if (win_c > NW'(MAX_WINDOW)) win_c = NW'(MAX_WINDOW);
    if (win_c > NW'(STORE_DEPTH + 1) - lags_c) win_c = NW'(STORE_DEPTH + 1) - lags_c;
    hop_c  = (hop_q == '0) ? NW'(1) : NW'(hop_q);
    need_c = win_c + lags_c - NW'(1);
  end

  // ---------------- stream state ----------------
  fnac_state_e          state_q, state_d;
  logic [AW-1:0]        wp_q, wp_d;
  logic [NW-1:0]        fill_q, fill_d;
  logic [HOP_REG_W-1:0] skip_q, skip_d;
  logic [FRAME_W-1:0]   frame_q, frame_d;

  // frame being computed
  logic [AW-1:0]        start_q, start_d;
  logic [NW-1:0]        winf_q, winf_d;
  logic [NW-1:0]        lagsf_q, lagsf_d;
  logic [FRAME_W-1:0]   curf_q, curf_d;
  logic [ETA_W-1:0]     eta_q, eta_d;
  logic [NW-1:0]        n_q, n_d;
  logic [AW-1:0]        a_ptr_q, a_ptr_d, b_ptr_q, b_ptr_d;

  logic                 in_acc, fire, clr, issue, mac_done, last_c;
  logic                 sc_start, sc_take;
  logic [NW-1:0]        fill_r, fill_inc, wp_ext, diff;
  logic [HOP_REG_W-1:0] skip_r;
  logic [FRAME_W-1:0]   frame_r;
  logic [AW-1:0]        start_c;
  logic [AW:0]          bsum;
  fnac_sc_req_t         sc_req;
  fnac_sc_sts_t         sc_sts;

  assign in_acc      = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign issue       = (state_q == ST_MAC) && (n_q != winf_q);
  assign last_c      = (NW'(eta_q) == lagsf_q - NW'(1));

  // ---------------- sample store ----------------
  logic [SAMPLE_BITS-1:0] mem_q [STORE_DEPTH];
  logic [SAMPLE_BITS-1:0] rd_a_q, rd_b_q;

  always_ff @(posedge clk_i) begin
    if (in_acc) mem_q[wp_q] <= in_if.sample;
    rd_a_q <= mem_q[a_ptr_q];
    rd_b_q <= mem_q[b_ptr_q];
  end

  // ---------------- MAC pipeline: read, multiply, accumulate ----------------
  logic                    v1_q, v2_q;
  logic signed [PRD_W-1:0] pab_q, pbb_q;
  logic signed [ACC_W-1:0] corr_q, en_q, r0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pab_q <= $signed(rd_a_q) * $signed(rd_b_q);
    pbb_q <= $signed(rd_b_q) * $signed(rd_b_q);
    if (clr) begin
      corr_q <= '0;
      en_q   <= '0;
    end else if (v2_q) begin
      corr_q <= corr_q + ACC_W'(pab_q);
      en_q   <= en_q + ACC_W'(pbb_q);
    end
    if (sc_req.start && eta_q == '0) r0_q <= corr_q;
  end

  assign mac_done = (state_q == ST_MAC) && (n_q == winf_q) && !v1_q && !v2_q;

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      wp_q    <= '0;
      fill_q  <= '0;
      skip_q  <= '0;
      frame_q <= '0;
      n_q     <= '0;
      eta_q   <= '0;
    end else begin
      state_q <= state_d;
      wp_q    <= wp_d;
      fill_q  <= fill_d;
      skip_q  <= skip_d;
      frame_q <= frame_d;
      n_q     <= n_d;
      eta_q   <= eta_d;
    end
  end

  always_ff @(posedge clk_i) begin
    start_q <= start_d;
    winf_q  <= winf_d;
    lagsf_q <= lagsf_d;
    curf_q  <= curf_d;
    a_ptr_q <= a_ptr_d;
    b_ptr_q <= b_ptr_d;
  end

  always_comb begin
    state_d = state_q;
    wp_d    = wp_q;
    fill_d  = fill_q;
    skip_d  = skip_q;
    frame_d = frame_q;
    start_d = start_q;
    winf_d  = winf_q;
    lagsf_d = lagsf_q;
    curf_d  = curf_q;
    eta_d   = eta_q;
    n_d     = n_q;
    a_ptr_d = a_ptr_q;
    b_ptr_d = b_ptr_q;
    clr     = 1'b0;
    fire    = 1'b0;
    sc_start = 1'b0;

    // restart applies before the sample is counted
    fill_r   = in_if.restart ? '0 : fill_q;
    skip_r   = in_if.restart ? '0 : skip_q;
    frame_r  = in_if.restart ? '0 : frame_q;
    fill_inc = (fill_r < NW'(STORE_DEPTH)) ? fill_r + NW'(1) : fill_r;
    wp_ext   = (wp_q == AW'(STORE_DEPTH - 1)) ? '0 : NW'(wp_q) + NW'(1);
    diff     = wp_ext - fill_inc;
    start_c  = (wp_ext >= fill_inc) ? AW'(diff) : AW'(diff + NW'(STORE_DEPTH));
    bsum     = {1'b0, start_q} + (AW + 1)'(eta_q + 1'b1);
    if (bsum >= (AW + 1)'(STORE_DEPTH)) bsum = bsum - (AW + 1)'(STORE_DEPTH);

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          wp_d    = AW'(wp_ext);
          fill_d  = fill_r;
          skip_d  = skip_r;
          frame_d = frame_r;
          if (frame_r < limit_q) begin
            if (skip_r != '0) begin
              skip_d = skip_r - 1'b1;
            end else begin
              fill_d = fill_inc;
              if (fill_inc >= need_c) begin
                fire    = 1'b1;
                frame_d = frame_r + 1'b1;
                if (fill_inc >= hop_c) begin
                  fill_d = fill_inc - hop_c;
                end else begin
                  skip_d = HOP_REG_W'(hop_c - fill_inc);
                  fill_d = '0;
                end
              end
            end
          end
          if (fire) begin
            start_d = start_c;
            winf_d  = win_c;
            lagsf_d = lags_c;
            curf_d  = frame_r;
            eta_d   = '0;
            n_d     = '0;
            a_ptr_d = start_c;
            b_ptr_d = start_c;
            clr     = 1'b1;
            state_d = ST_MAC;
          end
        end
      end
      ST_MAC: begin
        if (issue) begin
          n_d     = n_q + NW'(1);
          a_ptr_d = (a_ptr_q == AW'(STORE_DEPTH - 1)) ? '0 : a_ptr_q + 1'b1;
          b_ptr_d = (b_ptr_q == AW'(STORE_DEPTH - 1)) ? '0 : b_ptr_q + 1'b1;
        end
        if (mac_done) state_d = ST_HAND;
      end
      ST_HAND: begin
        if (!sc_sts.busy) begin
          sc_start = 1'b1;
          if (last_c) begin
            state_d = ST_IDLE;
          end else begin
            eta_d   = eta_q + 1'b1;
            n_d     = '0;
            a_ptr_d = start_q;
            b_ptr_d = AW'(bsum);
            clr     = 1'b1;
            state_d = ST_MAC;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------- scale unit and its side data ----------------
  logic [ACC_W-1:0]        sc_root;
  logic signed [ACC_W-1:0] m_corr_q;
  logic [ETA_W-1:0]        m_eta_q;
  logic                    m_last_q;
  logic [FRAME_W-1:0]      m_frame_q;
  logic                    out_vld_q;

  assign sc_take = sc_sts.done && (!out_vld_q || out_if.ready);
  assign sc_req  = '{start: sc_start, take: sc_take};

  always_ff @(posedge clk_i) begin
    if (sc_req.start) begin
      m_corr_q  <= corr_q;
      m_eta_q   <= eta_q;
      m_last_q  <= last_c;
      m_frame_q <= curf_q;
    end
  end

  fnac_scale #(
    .OP_W (ACC_W)
  ) u_scale (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (sc_req),
    .r0_i     ((eta_q == '0) ? corr_q : r0_q),
    .energy_i (en_q),
    .sts_o    (sc_sts),
    .root_o   (sc_root)
  );

  // ---------------- output register ----------------
  logic [LAG_IDX_W-1:0]     o_lag_q;
  logic signed [CORR_W-1:0] o_corr_q;
  logic [SCALE_W-1:0]       o_scale_q;
  logic [FRAME_W-1:0]       o_frame_q;
  logic                     o_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (sc_req.take) begin
      out_vld_q <= 1'b1;
    end else if (out_if.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sc_req.take) begin
      o_lag_q   <= LAG_IDX_W'(m_eta_q);
      o_corr_q  <= CORR_W'(m_corr_q);
      o_scale_q <= SCALE_W'(sc_root);
      o_frame_q <= m_frame_q;
      o_last_q  <= m_last_q;
    end
  end

  assign out_if.valid       = out_vld_q;
  assign out_if.lag_index   = o_lag_q;
  assign out_if.correlation = o_corr_q;
  assign out_if.scale       = o_scale_q;
  assign out_if.frame_index = o_frame_q;
  assign out_if.last_lag    = o_last_q;

  // ---------------- assertions ----------------
  a_start_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sc_req.start |-> !sc_sts.busy)
    else $error("scale unit started while busy");

  a_window_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_MAC |-> n_q <= winf_q)
    else $error("MAC issued past the window");

  a_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> state_q == ST_MAC)
    else $error("MAC pipeline not drained before hand-over");

endmodule

`default_nettype wire

>>> bench/framewise_normalized_autocorrelation_top_tb.sv
// Self-checking bench for framewise_normalized_autocorrelation_top: a built-in frame
// predictor, a random-gap sample driver and a stalling result monitor.
// Depends on fnac_pkg, fnac_sample_if, fnac_result_if and the block itself.
`default_nettype none

module framewise_normalized_autocorrelation_top_tb;
  import fnac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned DEPTH     = STORE_DEPTH_DEF;
  localparam int unsigned CYCLE_CAP = 4000000;
  localparam int unsigned DRAIN     = 400;   // idle margin after the last owed result

  typedef struct {
    logic [15:0] sample;
    logic        restart;
  } sample_beat_t;

  typedef struct {
    logic [LAG_IDX_W-1:0] lag_index;
    logic [CORR_W-1:0]    correlation;
    logic [SCALE_W-1:0]   scale;
    logic [FRAME_W-1:0]   frame_index;
    logic                 last_lag;
  } lag_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = CFG_WINDOW;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  fnac_sample_if in_if ();
  fnac_result_if out_if ();

  framewise_normalized_autocorrelation_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .out_if     (out_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state: own copy of the store, counters and registers
  // ---------------------------------------------------------------------------
  shortint     pend_store [DEPTH];
  int unsigned wr_ptr = 0, held = 0, frame_no = 0, gap_left = 0;
  int unsigned win_reg = 256, lags_reg = 64, hop_reg = 128, limit_reg = 65535;

  sample_beat_t sample_q[$];      // beats waiting to be driven
  lag_result_t  lag_results_q[$]; // results the block still owes us

  int unsigned beats_in = 0, results_ok = 0, results_seen = 0, frames_done = 0;
  int unsigned mismatches = 0, cycles = 0, settings_used = 0;
  bit          gaps_on = 1'b1;   // stimulus phases without source idling clear this
  bit          hold_req = 1'b0;  // ask the receiver for one long hold-off

  function automatic logic [63:0] floor_root(logic [127:0] n);
    logic [127:0] r, c;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      c = r | (128'd1 << i);
      if (c * c <= n) r = c;
    end
    return r[63:0];
  endfunction

  // Folds one accepted sample beat into the predictor, queueing any frame results.
  task automatic absorb_sample(logic [15:0] smp, logic rst_flag);
    int unsigned lags, win, hop, need, base;
    longint      corr, energy, a, b;
    logic [63:0] r0, sc;
    lag_result_t res;
    if (rst_flag) begin
      held = 0; gap_left = 0; frame_no = 0;
    end
    pend_store[wr_ptr] = $signed(smp);
    wr_ptr = (wr_ptr + 1) % DEPTH;
    if (frame_no >= limit_reg) return;
    if (gap_left > 0) begin
      gap_left--;
      return;
    end
    if (held < DEPTH) held++;
    lags = (lags_reg == 0) ? 1 : lags_reg;
    if (lags > MAX_LAGS_DEF) lags = MAX_LAGS_DEF;
    win = (win_reg == 0) ? 1 : win_reg;
    if (win > MAX_WINDOW_DEF) win = MAX_WINDOW_DEF;
    if (win > DEPTH - lags + 1) win = DEPTH - lags + 1;
    hop = (hop_reg == 0) ? 1 : hop_reg;
    need = win + lags - 1;
    if (held < need) return;
    base = (wr_ptr + DEPTH - held) % DEPTH;
    r0 = '0;
    for (int unsigned eta = 0; eta < lags; eta++) begin
      corr = 0; energy = 0;
      for (int unsigned n = 0; n < win; n++) begin
        a = longint'(pend_store[(base + n) % DEPTH]);
        b = longint'(pend_store[(base + n + eta) % DEPTH]);
        corr += a * b;
        energy += b * b;
      end
      if (eta == 0) r0 = corr;
      sc = floor_root({64'd0, r0} * {64'd0, energy[63:0]});
      res.lag_index   = eta[LAG_IDX_W-1:0];
      res.correlation = corr[CORR_W-1:0];
      res.scale       = sc[SCALE_W-1:0];
      res.frame_index = frame_no[FRAME_W-1:0];
      res.last_lag    = (eta + 1 == lags);
      lag_results_q.push_back(res);
    end
    frame_no++;
    frames_done++;
    if (held >= hop) held -= hop;
    else begin
      gap_left = hop - held;
      held = 0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sample driver: changes at the falling edge, acceptance seen at the rising edge
  // ---------------------------------------------------------------------------
  bit          in_fire = 1'b0;
  int unsigned src_gap = 0;

  initial begin
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.restart = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni && (in_fire || !in_if.valid)) begin
      if (src_gap > 0) begin
        src_gap--;
        in_if.valid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        in_if.valid   <= 1'b1;
        in_if.sample  <= sample_q[0].sample;
        in_if.restart <= sample_q[0].restart;
        void'(sample_q.pop_front());
        // mostly back to back, sometimes a short pause, rarely a long one
        if (gaps_on) begin
          case ($urandom_range(9))
            0, 1, 2: src_gap = $urandom_range(3, 1);
            3:       src_gap = $urandom_range(60, 15);
            default: src_gap = 0;
          endcase
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random ready, plus one long hold-off while beats keep coming
  // ---------------------------------------------------------------------------
  int unsigned sink_gap = 0, hold_cycles = 0;
  bit          hold_done = 1'b0;

  initial out_if.ready = 1'b0;

  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_cycles = 3000;
    end
    if (hold_cycles > 0) begin
      hold_cycles--;
      out_if.ready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      case ($urandom_range(9))
        0, 1:    sink_gap = $urandom_range(3, 1);
        2:       sink_gap = (gaps_on) ? $urandom_range(80, 20) : 0;
        default: sink_gap = 0;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Rising edge: record accepted samples, check results, watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    lag_result_t want;
    cycles++;
    in_fire <= in_if.valid && in_if.ready;
    if (rst_ni && in_if.valid && in_if.ready) begin
      beats_in++;
      absorb_sample(in_if.sample, in_if.restart);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_seen++;
      if (lag_results_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] unexpected result beat: lag %0d frame %0d", $realtime,
                   out_if.lag_index, out_if.frame_index);
      end else begin
        want = lag_results_q.pop_front();
        if (want.lag_index !== out_if.lag_index || want.correlation !== out_if.correlation ||
            want.scale !== out_if.scale || want.frame_index !== out_if.frame_index ||
            want.last_lag !== out_if.last_lag) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] result mismatch, expected lag %0d corr %0d scale %0d frame %0d last %0b",
                     $realtime, want.lag_index, $signed(want.correlation), want.scale,
                     want.frame_index, want.last_lag);
            $display("            got lag %0d corr %0d scale %0d frame %0d last %0b",
                     out_if.lag_index, $signed(out_if.correlation), out_if.scale,
                     out_if.frame_index, out_if.last_lag);
          end
        end else begin
          results_ok++;
        end
      end
    end
    if (cycles >= CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               lag_results_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic write_reg(fnac_cfg_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_WINDOW: win_reg   = value & 11'h7FF;
      CFG_LAGS:   lags_reg  = value & 7'h7F;
      CFG_HOP:    hop_reg   = value & 11'h7FF;
      CFG_LIMIT:  limit_reg = value & 16'hFFFF;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned w, int unsigned l, int unsigned h, int unsigned lim);
    write_reg(CFG_WINDOW, w);
    write_reg(CFG_LAGS, l);
    write_reg(CFG_HOP, h);
    write_reg(CFG_LIMIT, lim);
    settings_used++;
  endtask

  // Block must be idle: nothing queued, nothing in flight, nothing owed.
  task automatic settle();
    do @(posedge clk_i);
    while (sample_q.size() > 0 || in_if.valid || lag_results_q.size() > 0);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic push_beat(logic [15:0] smp, logic rst_flag);
    sample_beat_t bt;
    bt.sample = smp;
    bt.restart = rst_flag;
    sample_q.push_back(bt);
  endtask

  // Random samples; restarts are rare so frames get through.
  task automatic push_random(int unsigned count, int unsigned restart_odds);
    logic [15:0] smp;
    for (int unsigned i = 0; i < count; i++) begin
      case ($urandom_range(15))
        0:       smp = 16'h7FFF;
        1:       smp = 16'h8000;
        2:       smp = 16'($urandom_range(3) - 1);
        default: smp = 16'($urandom());
      endcase
      push_beat(smp, (restart_odds != 0) && ($urandom_range(restart_odds - 1) == 0));
    end
  endtask

  initial begin
    int unsigned w, l, h, lim;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset settings: extremes of the sample range at the front of one full frame.
    settings_used = 1;
    push_beat(16'h7FFF, 1'b1);
    push_beat(16'h8000, 1'b0);
    push_beat(16'h0000, 1'b0);
    push_beat(16'h0001, 1'b0);
    push_beat(16'hFFFF, 1'b0);
    push_random(314, 0);
    settle();

    // Tiny frames with restart mid stream; the receiver holds off so the block backs up.
    set_regs(4, 3, 2, 65535);
    gaps_on = 1'b0;
    hold_req = 1'b1;
    push_random(8, 0);
    push_beat(16'h8000, 1'b1);
    push_random(8, 0);
    settle();
    gaps_on = 1'b1;

    // Zero registers act as one.
    set_regs(0, 0, 0, 65535);
    push_random(6, 0);
    settle();

    // Oversized lag count is clipped to the maximum; the long hop leaves a skip.
    set_regs(1, 127, 100, 65535);
    push_beat(16'h8000, 1'b1);
    push_random(63, 0);
    settle();

    // Frame limit zero: nothing comes out; then a limit of three with two restarts.
    set_regs(2, 2, 1, 0);
    push_random(5, 0);
    settle();
    write_reg(CFG_LIMIT, 3);
    push_beat(16'h1234, 1'b1);
    push_random(6, 0);
    push_beat(16'hEDCB, 1'b1);
    push_random(4, 0);
    settle();

    // Random settings, small sizes.
    for (int p = 0; p < 3; p++) begin
      w = $urandom_range(6, 1);
      l = $urandom_range(3, 1);
      h = $urandom_range(10, 1);
      lim = ($urandom_range(1) == 0) ? $urandom_range(4, 1) : 65535;
      set_regs(w, l, h, lim);
      gaps_on = (p != 2);
      push_beat(16'($urandom()), 1'b1);
      push_random($urandom_range(8, 5), 8);
      settle();
    end
    gaps_on = 1'b1;

    $display("Drove %0d sample beats over %0d register settings; %0d frames predicted.",
             beats_in, settings_used, frames_done);
    $display("Checked %0d of %0d result beats, %0d mismatches.", results_ok, results_seen,
             mismatches);
    if (mismatches == 0 && lag_results_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
